@@ src/bap_pkg.sv @@
// ============================================================================
// Block average pixelate package
// Shared widths, register indexes, payload types and helper functions.
// ============================================================================
`default_nettype none

package bap_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_BLOCK = 64;
	localparam int ROW_LIMIT = 4096;

	localparam int COL_W = 12;
	localparam int ROW_W = 12;
	localparam int OFS_W = 6;
	localparam int BS_W  = 7;
	localparam int DIM_W = 13;
	localparam int CFG_W = 13;
	localparam int IDX_W = 2;
	localparam int SUM_W = 20;
	localparam int SQ_W  = 13;
	localparam int AVG_W = 8;
	localparam int PIX_W = 8;

	localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [BS_W-1:0]  RESET_BLOCK  = 7'd30;
	localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int POS_STEPS = COL_W;
	localparam int POS_CNT_W = $clog2(POS_STEPS);
	localparam int AVG_STEPS = AVG_W;
	localparam int AVG_CNT_W = $clog2(AVG_STEPS);

	localparam int NUM_CH   = 3;
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	localparam logic [AVG_W-1:0] AVG_MAX = 8'hFF;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_red;
		logic [PIX_W-1:0] pixel_green;
		logic [PIX_W-1:0] pixel_blue;
	} pixel_t;

	typedef struct packed {
		logic [COL_W-1:0] block_column;
		logic [ROW_W-1:0] block_row;
		logic [AVG_W-1:0] avg_red;
		logic [AVG_W-1:0] avg_green;
		logic [AVG_W-1:0] avg_blue;
		logic             frame_done;
	} result_t;

	typedef struct packed {
		logic [COL_W-1:0] block_column;
		logic [ROW_W-1:0] block_row;
		logic             first;
		logic             emit;
		logic             frame_done;
		pixel_t           pixel;
	} queue_entry_t;

	typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

	typedef struct packed {
		logic [COL_W-1:0] block_column;
		logic [ROW_W-1:0] block_row;
		logic             frame_done;
		sums_t            sums;
	} avg_req_t;

	typedef struct packed {
		logic [BS_W-1:0]  block_size;
		logic [COL_W-1:0] last_column;
		logic [ROW_W-1:0] last_row;
		logic             resize;
	} frame_cfg_t;

	function automatic logic [BS_W-1:0] clamp_block(input logic [BS_W-1:0] v);
		logic [BS_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = BS_W'(1);
		end else if (v > BS_W'(MAX_BLOCK)) begin
			r = BS_W'(MAX_BLOCK);
		end
		return r;
	endfunction

	function automatic logic [COL_W-1:0] last_index(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] c;
		c = v;
		if (v == '0) begin
			c = DIM_W'(1);
		end else if (v > limit) begin
			c = limit;
		end
		return COL_W'(c - DIM_W'(1));
	endfunction

endpackage

`default_nettype wire

@@ src/bap_front.sv @@
// ============================================================================
// Block average pixelate front end
// Accepts pixels, tracks frame and block positions and classifies each pixel.
// ============================================================================
`default_nettype none

module bap_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire bap_pkg::pixel_t       in_pixel,
	input  wire bap_pkg::frame_cfg_t   cfg,
	input  wire logic                  q_full,
	output logic                       q_push,
	output bap_pkg::queue_entry_t      q_entry
);

	typedef enum logic [1:0] {
		F_RUN = 2'b01,
		F_DIV = 2'b10
	} front_state_t;

	front_state_t                     state_q;
	logic [bap_pkg::COL_W-1:0]        pcol_q;
	logic [bap_pkg::ROW_W-1:0]        prow_q;
	logic [bap_pkg::OFS_W-1:0]        offx_q;
	logic [bap_pkg::OFS_W-1:0]        offy_q;
	logic [bap_pkg::COL_W-1:0]        bcol_q;
	logic [bap_pkg::ROW_W-1:0]        brow_q;
	logic [bap_pkg::OFS_W-1:0]        crem_q;
	logic [bap_pkg::OFS_W-1:0]        rrem_q;
	logic [bap_pkg::POS_CNT_W-1:0]    step_q;

	logic [bap_pkg::OFS_W-1:0]        bs_last;
	logic                             row_end;
	logic                             last_row;
	logic                             bx_end;
	logic                             by_end;
	logic                             accept;
	logic [bap_pkg::BS_W-1:0]         crem_sh;
	logic [bap_pkg::BS_W-1:0]         rrem_sh;
	logic                             c_ge;
	logic                             r_ge;
	logic [bap_pkg::BS_W-1:0]         crem_nx;
	logic [bap_pkg::BS_W-1:0]         rrem_nx;

	assign bs_last  = bap_pkg::OFS_W'(cfg.block_size - bap_pkg::BS_W'(1));
	assign row_end  = pcol_q >= cfg.last_column;
	assign last_row = prow_q >= cfg.last_row;
	assign bx_end   = (offx_q >= bs_last) || row_end;
	assign by_end   = (offy_q >= bs_last) || last_row;

	assign in_stall = (state_q != F_RUN) || q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = accept;

	assign q_entry.block_column = bcol_q;
	assign q_entry.block_row    = brow_q;
	assign q_entry.first        = (offx_q == '0) && (offy_q == '0);
	assign q_entry.emit         = bx_end && by_end;
	assign q_entry.frame_done   = row_end && last_row;
	assign q_entry.pixel        = in_pixel;

	// Restoring division of the pixel position by the block size, one bit per cycle.
	assign crem_sh = {crem_q, bcol_q[bap_pkg::COL_W-1]};
	assign rrem_sh = {rrem_q, brow_q[bap_pkg::ROW_W-1]};
	assign c_ge    = crem_sh >= cfg.block_size;
	assign r_ge    = rrem_sh >= cfg.block_size;
	assign crem_nx = c_ge ? crem_sh - cfg.block_size : crem_sh;
	assign rrem_nx = r_ge ? rrem_sh - cfg.block_size : rrem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_RUN;
			pcol_q  <= '0;
			prow_q  <= '0;
			offx_q  <= '0;
			offy_q  <= '0;
			bcol_q  <= '0;
			brow_q  <= '0;
			crem_q  <= '0;
			rrem_q  <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_RUN: begin
					if (accept) begin
						if (row_end) begin
							pcol_q <= '0;
							offx_q <= '0;
							bcol_q <= '0;
							crem_q <= '0;
							if (last_row) begin
								prow_q <= '0;
								offy_q <= '0;
								brow_q <= '0;
								rrem_q <= '0;
							end else begin
								prow_q <= prow_q + bap_pkg::ROW_W'(1);
								offy_q <= (offy_q >= bs_last) ? '0
									: offy_q + bap_pkg::OFS_W'(1);
								if (rrem_q >= bs_last) begin
									rrem_q <= '0;
									brow_q <= brow_q + bap_pkg::ROW_W'(1);
								end else begin
									rrem_q <= rrem_q + bap_pkg::OFS_W'(1);
								end
							end
						end else begin
							pcol_q <= pcol_q + bap_pkg::COL_W'(1);
							offx_q <= (offx_q >= bs_last) ? '0
								: offx_q + bap_pkg::OFS_W'(1);
							if (crem_q >= bs_last) begin
								crem_q <= '0;
								bcol_q <= bcol_q + bap_pkg::COL_W'(1);
							end else begin
								crem_q <= crem_q + bap_pkg::OFS_W'(1);
							end
						end
					end
				end
				F_DIV: begin
					bcol_q <= {bcol_q[bap_pkg::COL_W-2:0], c_ge};
					brow_q <= {brow_q[bap_pkg::ROW_W-2:0], r_ge};
					crem_q <= crem_nx[bap_pkg::OFS_W-1:0];
					rrem_q <= rrem_nx[bap_pkg::OFS_W-1:0];
					step_q <= step_q + bap_pkg::POS_CNT_W'(1);
					if (step_q == bap_pkg::POS_CNT_W'(bap_pkg::POS_STEPS - 1)) begin
						state_q <= F_RUN;
					end
				end
				default: begin
					state_q <= F_RUN;
				end
			endcase
			if (cfg.resize) begin
				state_q <= F_DIV;
				bcol_q  <= pcol_q;
				brow_q  <= prow_q;
				crem_q  <= '0;
				rrem_q  <= '0;
				step_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/bap_fifo.sv @@
// ============================================================================
// Block average pixelate queue
// Short register queue of classified pixels between front end and back end.
// ============================================================================
`default_nettype none

module bap_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire bap_pkg::queue_entry_t  push_entry,
	input  wire logic                   pop,
	output bap_pkg::queue_entry_t       head,
	output logic                        full,
	output logic                        empty
);

	bap_pkg::queue_entry_t            slots_q [bap_pkg::FIFO_DEPTH];
	logic [bap_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [bap_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [bap_pkg::FIFO_CW-1:0]      count_q;

	assign head  = slots_q[rd_ptr_q];
	assign full  = count_q == bap_pkg::FIFO_CW'(bap_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bap_pkg::FIFO_AW'(bap_pkg::FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + bap_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bap_pkg::FIFO_AW'(bap_pkg::FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + bap_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bap_pkg::FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bap_pkg::FIFO_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ src/bap_avg_div.sv @@
// ============================================================================
// Block average pixelate averaging divider
// Divides the three colour sums by the squared block size, one quotient bit
// per cycle, and holds the finished result in the output register.
// ============================================================================
`default_nettype none

module bap_avg_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [bap_pkg::SQ_W-1:0] block_sq,
	input  wire logic                   start,
	input  wire bap_pkg::avg_req_t      req,
	output logic                        idle,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output bap_pkg::result_t            out_block
);

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_RUN  = 3'b010,
		A_DONE = 3'b100
	} avg_state_t;

	avg_state_t                                     state_q;
	logic [bap_pkg::AVG_CNT_W-1:0]                  step_q;
	logic                                           out_valid_q;
	bap_pkg::result_t                               out_q;
	bap_pkg::sums_t                                 rem_q;
	logic [bap_pkg::NUM_CH-1:0][bap_pkg::AVG_W-1:0] quo_q;
	logic [bap_pkg::NUM_CH-1:0]                     sat_q;
	logic [bap_pkg::SUM_W-1:0]                      dvs_q;
	logic [bap_pkg::COL_W-1:0]                      col_q;
	logic [bap_pkg::ROW_W-1:0]                      row_q;
	logic                                           fd_q;

	logic [bap_pkg::NUM_CH-1:0]                     ge;
	bap_pkg::sums_t                                 rem_nx;
	logic [bap_pkg::NUM_CH-1:0]                     sat_nx;
	logic                                           load;
	bap_pkg::result_t                               res;

	always_comb begin
		for (int ch = 0; ch < bap_pkg::NUM_CH; ch++) begin
			ge[ch]     = rem_q[ch] >= dvs_q;
			rem_nx[ch] = ge[ch] ? rem_q[ch] - dvs_q : rem_q[ch];
			sat_nx[ch] = {1'b0, req.sums[ch]} >= {block_sq, 8'd0};
		end
	end

	assign res.block_column = col_q;
	assign res.block_row    = row_q;
	assign res.avg_red      = sat_q[bap_pkg::CH_RED] ? bap_pkg::AVG_MAX
		: quo_q[bap_pkg::CH_RED];
	assign res.avg_green    = sat_q[bap_pkg::CH_GREEN] ? bap_pkg::AVG_MAX
		: quo_q[bap_pkg::CH_GREEN];
	assign res.avg_blue     = sat_q[bap_pkg::CH_BLUE] ? bap_pkg::AVG_MAX
		: quo_q[bap_pkg::CH_BLUE];
	assign res.frame_done   = fd_q;

	assign load      = (state_q == A_DONE) && (!out_valid_q || !out_stall);
	assign idle      = state_q == A_IDLE;
	assign out_valid = out_valid_q;
	assign out_block = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= A_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (start) begin
						state_q <= A_RUN;
						step_q  <= '0;
					end
				end
				A_RUN: begin
					step_q <= step_q + bap_pkg::AVG_CNT_W'(1);
					if (step_q == bap_pkg::AVG_CNT_W'(bap_pkg::AVG_STEPS - 1)) begin
						state_q <= A_DONE;
					end
				end
				A_DONE: begin
					if (load) begin
						state_q <= A_IDLE;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (idle && start) begin
			rem_q <= req.sums;
			sat_q <= sat_nx;
			dvs_q <= {block_sq, 7'd0};
			quo_q <= '0;
			col_q <= req.block_column;
			row_q <= req.block_row;
			fd_q  <= req.frame_done;
		end else if (state_q == A_RUN) begin
			rem_q <= rem_nx;
			dvs_q <= dvs_q >> 1;
			for (int ch = 0; ch < bap_pkg::NUM_CH; ch++) begin
				quo_q[ch] <= {quo_q[ch][bap_pkg::AVG_W-2:0], ge[ch]};
			end
		end
		if (load) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ src/bap_back.sv @@
// ============================================================================
// Block average pixelate back end
// Accumulates colour sums per block column in the sum memory and passes
// finished blocks to the averaging divider.
// ============================================================================
`default_nettype none

module bap_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [bap_pkg::BS_W-1:0] block_size,
	input  wire logic                     q_empty,
	input  wire bap_pkg::queue_entry_t    q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output bap_pkg::result_t              out_block
);

	localparam int SUM_DEPTH = bap_pkg::MAX_WIDTH;
	localparam int SUM_AW    = $clog2(SUM_DEPTH);

	bap_pkg::sums_t                 sum_mem [SUM_DEPTH];
	bap_pkg::sums_t                 rd_q;
	bap_pkg::sums_t                 last_q;
	logic                           valid_s2;
	bap_pkg::queue_entry_t          entry_s2;
	logic                           fwd_s2;
	logic [bap_pkg::SQ_W-1:0]       bs_sq_q;

	bap_pkg::sums_t                 old_sum;
	bap_pkg::sums_t                 pix_ext;
	bap_pkg::sums_t                 new_sum;
	logic                           div_idle;
	logic                           fire_s2;
	bap_pkg::avg_req_t              req;

	assign pix_ext[bap_pkg::CH_RED]   = {{(bap_pkg::SUM_W-bap_pkg::PIX_W){1'b0}},
		entry_s2.pixel.pixel_red};
	assign pix_ext[bap_pkg::CH_GREEN] = {{(bap_pkg::SUM_W-bap_pkg::PIX_W){1'b0}},
		entry_s2.pixel.pixel_green};
	assign pix_ext[bap_pkg::CH_BLUE]  = {{(bap_pkg::SUM_W-bap_pkg::PIX_W){1'b0}},
		entry_s2.pixel.pixel_blue};

	// The previous transaction's write to the same column is not yet in the read data.
	assign old_sum = fwd_s2 ? last_q : rd_q;

	always_comb begin
		for (int ch = 0; ch < bap_pkg::NUM_CH; ch++) begin
			new_sum[ch] = entry_s2.first ? pix_ext[ch] : old_sum[ch] + pix_ext[ch];
		end
	end

	assign fire_s2 = valid_s2 && (!entry_s2.emit || div_idle);
	assign q_pop   = !q_empty && (!valid_s2 || fire_s2);

	assign req.block_column = entry_s2.block_column;
	assign req.block_row    = entry_s2.block_row;
	assign req.frame_done   = entry_s2.frame_done;
	assign req.sums         = new_sum;

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			sum_mem[entry_s2.block_column[SUM_AW-1:0]] <= new_sum;
		end
		if (q_pop) begin
			rd_q <= sum_mem[q_head.block_column[SUM_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		bs_sq_q <= {6'd0, block_size} * {6'd0, block_size};
		if (fire_s2) begin
			last_q <= new_sum;
		end
		if (q_pop) begin
			entry_s2 <= q_head;
			fwd_s2   <= fire_s2 && (entry_s2.block_column == q_head.block_column);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (q_pop) begin
			valid_s2 <= 1'b1;
		end else if (fire_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	bap_avg_div u_avg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.block_sq  (bs_sq_q),
		.start     (fire_s2 && entry_s2.emit),
		.req       (req),
		.idle      (div_idle),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_block (out_block)
	);

endmodule

`default_nettype wire

@@ src/block_average_pixelate.sv @@
// ============================================================================
// Block average pixelate
// Tiles a raster-order RGB frame into square blocks and reports the truncated
// average colour of each block when its last pixel arrives.
// ============================================================================
// Throughput: one pixel per cycle while the input is not stalled; a pixel
// that completes a block keeps the bit-serial averaging divider busy, and
// the next such pixel waits for it. A block result passes from its last
// pixel through the queue, the sum stage, the divider and output register.
// A block_size write stalls the input while the position divider recomputes
// the block column and block row.
// Reset clears all counters and control state and loads the register reset
// values; the sum memory is not cleared.
`default_nettype none

module block_average_pixelate (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire bap_pkg::pixel_t            in_pixel,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output bap_pkg::result_t                out_block,
	input  wire logic                       cfg_write,
	input  wire logic [bap_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [bap_pkg::CFG_W-1:0]  cfg_data
);

	logic [bap_pkg::BS_W-1:0]     block_size_q;
	logic [bap_pkg::DIM_W-1:0]    image_width_q;
	logic [bap_pkg::DIM_W-1:0]    image_height_q;

	bap_pkg::frame_cfg_t          frame_cfg;
	bap_pkg::queue_entry_t        push_entry;
	bap_pkg::queue_entry_t        head;
	logic                         fifo_push;
	logic                         fifo_pop;
	logic                         fifo_full;
	logic                         fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= bap_pkg::RESET_BLOCK;
			image_width_q  <= bap_pkg::RESET_WIDTH;
			image_height_q <= bap_pkg::RESET_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				bap_pkg::REG_BLOCK_SIZE: begin
					block_size_q <= cfg_data[bap_pkg::BS_W-1:0];
				end
				bap_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data;
				end
				bap_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign frame_cfg.block_size  = bap_pkg::clamp_block(block_size_q);
	assign frame_cfg.last_column = bap_pkg::last_index(image_width_q,
		bap_pkg::DIM_W'(bap_pkg::MAX_WIDTH));
	assign frame_cfg.last_row    = bap_pkg::last_index(image_height_q,
		bap_pkg::DIM_W'(bap_pkg::ROW_LIMIT));
	assign frame_cfg.resize      = cfg_write && (cfg_index == bap_pkg::REG_BLOCK_SIZE);

	bap_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_pixel (in_pixel),
		.cfg      (frame_cfg),
		.q_full   (fifo_full),
		.q_push   (fifo_push),
		.q_entry  (push_entry)
	);

	bap_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fifo_push),
		.push_entry (push_entry),
		.pop        (fifo_pop),
		.head       (head),
		.full       (fifo_full),
		.empty      (fifo_empty)
	);

	bap_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.block_size (frame_cfg.block_size),
		.q_empty    (fifo_empty),
		.q_head     (head),
		.q_pop      (fifo_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_block  (out_block)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> !fifo_empty)
		else $error("queue read while empty");

	a_resize_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		frame_cfg.resize |=> in_stall)
		else $error("input not stalled after a block size write");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Block average pixelate testbench
// Streams frames of RGB pixels through the block with random gaps on the
// pixel side and random stalls on the result side. A local model of the
// block-average tiling predicts every block result, and each result
// transaction is compared field by field in order. The run covers the reset
// register values, out-of-range register values, register writes in the
// middle of a frame, saturated averages, and many small random frames.
// ============================================================================

module tb_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 32;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 40;
	localparam int RANDOM_PIXELS  = 1100;
	localparam int IDLE_PERCENT   = 31;
	localparam int QUIET_START    = 1600;
	localparam int QUIET_END      = 2800;

	localparam bap_pkg::pixel_t FULL_WHITE   = {8'hFF, 8'hFF, 8'hFF};
	localparam bap_pkg::pixel_t FULL_BLACK   = {8'h00, 8'h00, 8'h00};
	localparam bap_pkg::pixel_t MAGENTA_TINT = {8'hFF, 8'h00, 8'hAA};
	localparam bap_pkg::pixel_t DIM_TEAL     = {8'h01, 8'h80, 8'h7F};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	bap_pkg::pixel_t           in_pixel = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	bap_pkg::result_t          out_block;
	logic                      cfg_write = 1'b0;
	logic [bap_pkg::IDX_W-1:0] cfg_index = bap_pkg::REG_BLOCK_SIZE;
	logic [bap_pkg::CFG_W-1:0] cfg_data = '0;

	// Local copy of the tiling state and register settings.
	int unsigned               red_acc [bap_pkg::MAX_WIDTH];
	int unsigned               green_acc [bap_pkg::MAX_WIDTH];
	int unsigned               blue_acc [bap_pkg::MAX_WIDTH];
	int unsigned               col_pos = 0;
	int unsigned               row_pos = 0;
	int unsigned               step_x = 0;
	int unsigned               step_y = 0;
	logic [bap_pkg::BS_W-1:0]  block_side = bap_pkg::RESET_BLOCK;
	logic [bap_pkg::DIM_W-1:0] frame_width = bap_pkg::RESET_WIDTH;
	logic [bap_pkg::DIM_W-1:0] frame_height = bap_pkg::RESET_HEIGHT;

	bap_pkg::result_t          pending_blocks [$];
	bap_pkg::pixel_t           pixel_queue [$];
	bap_pkg::result_t          oldest_block;
	int unsigned               pixels_pushed = 0;
	int unsigned               pixels_taken = 0;
	int unsigned               blocks_checked = 0;
	int unsigned               fail_count = 0;
	int unsigned               cycle_count = 0;
	int unsigned               stuck_cycles = 0;
	int unsigned               hold_left = 0;
	logic                      hold_done = 1'b0;
	logic                      quiet_spell;

	assign quiet_spell = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

	block_average_pixelate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_pixel  (in_pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_block (out_block),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10;
		clk = 1'b1;
		#10;
		clk = 1'b0;
	end

	function automatic int unsigned limit_dim(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [bap_pkg::AVG_W-1:0] clip_avg(input int unsigned q);
		return (q > 255) ? bap_pkg::AVG_MAX : bap_pkg::AVG_W'(q);
	endfunction

	function automatic int unsigned frame_pixels();
		return limit_dim(frame_width, bap_pkg::MAX_WIDTH)
			* limit_dim(frame_height, bap_pkg::ROW_LIMIT);
	endfunction

	function automatic logic [bap_pkg::PIX_W-1:0] random_level();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return bap_pkg::PIX_W'($urandom_range(255));
		endcase
	endfunction

	function automatic bap_pkg::pixel_t random_pixel();
		bap_pkg::pixel_t px;
		px.pixel_red = random_level();
		px.pixel_green = random_level();
		px.pixel_blue = random_level();
		return px;
	endfunction

	// Adds one pixel to the running block sums and queues the block result
	// when this pixel closes a block.
	task automatic fold_pixel(input bap_pkg::pixel_t px);
		int unsigned      side, width, height, bcol, area;
		logic             row_end, last_row, x_end, y_end;
		bap_pkg::result_t blk;
		side = limit_dim(block_side, bap_pkg::MAX_BLOCK);
		width = limit_dim(frame_width, bap_pkg::MAX_WIDTH);
		height = limit_dim(frame_height, bap_pkg::ROW_LIMIT);
		bcol = col_pos / side;
		if (bcol >= bap_pkg::MAX_WIDTH) bcol = bap_pkg::MAX_WIDTH - 1;
		row_end = col_pos >= width - 1;
		last_row = row_pos >= height - 1;
		x_end = step_x >= side - 1 || row_end;
		y_end = step_y >= side - 1 || last_row;
		if (step_x == 0 && step_y == 0) begin
			red_acc[bcol] = px.pixel_red;
			green_acc[bcol] = px.pixel_green;
			blue_acc[bcol] = px.pixel_blue;
		end else begin
			red_acc[bcol] += px.pixel_red;
			green_acc[bcol] += px.pixel_green;
			blue_acc[bcol] += px.pixel_blue;
		end
		if (x_end && y_end) begin
			area = side * side;
			blk.block_column = bap_pkg::COL_W'(bcol);
			blk.block_row = bap_pkg::ROW_W'(row_pos / side);
			blk.avg_red = clip_avg(red_acc[bcol] / area);
			blk.avg_green = clip_avg(green_acc[bcol] / area);
			blk.avg_blue = clip_avg(blue_acc[bcol] / area);
			blk.frame_done = row_end && last_row;
			pending_blocks.push_back(blk);
		end
		if (row_end) begin
			col_pos = 0;
			step_x = 0;
			if (last_row) begin
				row_pos = 0;
				step_y = 0;
			end else begin
				row_pos++;
				step_y = (step_y >= side - 1) ? 0 : step_y + 1;
			end
		end else begin
			col_pos++;
			step_x = (step_x >= side - 1) ? 0 : step_x + 1;
		end
	endtask

	task automatic check_field(input string label, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, label, want, got);
			fail_count++;
		end
	endtask

	task automatic write_reg(input logic [bap_pkg::IDX_W-1:0] index,
		input int unsigned value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= bap_pkg::CFG_W'(value);
		case (index)
			bap_pkg::REG_BLOCK_SIZE: block_side = bap_pkg::BS_W'(value);
			bap_pkg::REG_IMAGE_WIDTH: frame_width = bap_pkg::DIM_W'(value);
			bap_pkg::REG_IMAGE_HEIGHT: frame_height = bap_pkg::DIM_W'(value);
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic offer(input bap_pkg::pixel_t px);
		pixel_queue.push_back(px);
		pixels_pushed++;
	endtask

	// Waits until every pixel has been taken and every block has come out,
	// then lets the pipeline drain pixels that close no block.
	task automatic settle();
		while (pixels_taken != pixels_pushed || pending_blocks.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned side, input int unsigned width,
		input int unsigned height);
		settle();
		write_reg(bap_pkg::REG_BLOCK_SIZE, side);
		write_reg(bap_pkg::REG_IMAGE_WIDTH, width);
		write_reg(bap_pkg::REG_IMAGE_HEIGHT, height);
	endtask

	// Sends the pixels still missing from the current frame so that every
	// position counter ends up back at zero.
	task automatic finish_frame(input bit all_white, output int unsigned count);
		int unsigned width, height;
		width = limit_dim(frame_width, bap_pkg::MAX_WIDTH);
		height = limit_dim(frame_height, bap_pkg::ROW_LIMIT);
		count = (col_pos >= width - 1) ? 1 : width - col_pos;
		if (row_pos < height - 1) count += (height - 1 - row_pos) * width;
		repeat (count) offer(all_white ? FULL_WHITE : random_pixel());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_pixel <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				fold_pixel(in_pixel);
				pixels_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_queue.size() != 0 &&
					(quiet_spell || $urandom_range(99) >= IDLE_PERCENT)) begin
					in_valid <= 1'b1;
					in_pixel <= pixel_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_blocks.size() == 0) begin
					$display("%0t: unexpected block column %0d row %0d", $time,
						out_block.block_column, out_block.block_row);
					fail_count++;
				end else begin
					oldest_block = pending_blocks.pop_front();
					check_field("block_column", oldest_block.block_column,
						out_block.block_column);
					check_field("block_row", oldest_block.block_row, out_block.block_row);
					check_field("avg_red", oldest_block.avg_red, out_block.avg_red);
					check_field("avg_green", oldest_block.avg_green, out_block.avg_green);
					check_field("avg_blue", oldest_block.avg_blue, out_block.avg_blue);
					check_field("frame_done", oldest_block.frame_done,
						out_block.frame_done);
				end
				blocks_checked++;
			end
			if (!hold_done && blocks_checked >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_spell && $urandom_range(99) < IDLE_PERCENT;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned total, part, tail, random_count;
		random_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Block size and height keep their reset values.
		write_reg(bap_pkg::REG_IMAGE_WIDTH, 1);
		repeat (frame_pixels()) offer(random_pixel());

		// Registers below their range; one block per pixel over every column
		// that later frames can reach.
		set_frame(0, 48, 0);
		repeat (frame_pixels()) offer(random_pixel());

		// Registers above their range, then new limits end the frame early.
		set_frame(100, 4097, 4097);
		repeat (bap_pkg::MAX_BLOCK) offer(FULL_WHITE);
		settle();
		write_reg(bap_pkg::REG_IMAGE_HEIGHT, 1);
		write_reg(bap_pkg::REG_IMAGE_WIDTH, bap_pkg::MAX_BLOCK + 2);
		finish_frame(1'b1, tail);

		// Partial blocks at the right and bottom edges.
		set_frame(2, 3, 3);
		offer(FULL_WHITE);
		offer(FULL_WHITE);
		offer(MAGENTA_TINT);
		offer(FULL_WHITE);
		offer(FULL_WHITE);
		offer(DIM_TEAL);
		offer(FULL_BLACK);
		offer(MAGENTA_TINT);
		offer(FULL_WHITE);

		set_frame(bap_pkg::MAX_BLOCK, 2, 1);
		offer(FULL_WHITE);
		offer(FULL_WHITE);

		// Shrinking the block mid-frame pushes the average past 255.
		set_frame(4, 4, 4);
		repeat (12) offer(FULL_WHITE);
		settle();
		write_reg(bap_pkg::REG_BLOCK_SIZE, 2);
		finish_frame(1'b1, tail);

		while (random_count < RANDOM_PIXELS) begin
			set_frame(($urandom_range(7) == 0) ? $urandom_range(0, 70) : $urandom_range(1, 6),
				($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40),
				$urandom_range(1, 12));
			total = frame_pixels();
			if (total > 1 && $urandom_range(3) == 0) begin
				part = $urandom_range(1, total - 1);
				repeat (part) offer(random_pixel());
				settle();
				case ($urandom_range(2))
					0: write_reg(bap_pkg::REG_BLOCK_SIZE, ($urandom_range(3) == 0) ?
						$urandom_range(127) : $urandom_range(1, 8));
					1: write_reg(bap_pkg::REG_IMAGE_WIDTH, $urandom_range(0, 48));
					default: write_reg(bap_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 16));
				endcase
				finish_frame(1'b0, tail);
				random_count += part + tail;
			end else begin
				repeat (total) offer(random_pixel());
				random_count += total;
			end
		end

		settle();
		if (fail_count == 0 && pending_blocks.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/bap_pkg.sv
src/bap_front.sv
src/bap_fifo.sv
src/bap_avg_div.sv
src/bap_back.sv
src/block_average_pixelate.sv
verif/tb_top.sv
